// ===== rtl/pngu_pkg.sv =====
// Shared types and constants of the PNG scanline unfilter.
`timescale 1ns / 1ps
package pngu_pkg;

  // Widths fixed by the register map and the item fields.
  localparam int BPP_W        = 4;
  localparam int ROW_BYTES_W  = 14;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 14;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES       = 2'd1;

  // Filter type codes carried with each byte; any other value is invalid.
  localparam logic [7:0] FILTER_NONE  = 8'd0;
  localparam logic [7:0] FILTER_SUB   = 8'd1;
  localparam logic [7:0] FILTER_UP    = 8'd2;
  localparam logic [7:0] FILTER_AVG   = 8'd3;
  localparam logic [7:0] FILTER_PAETH = 8'd4;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

  // One filtered byte as it arrives.
  typedef struct packed {
    logic [7:0] filter_type;
    logic [7:0] data_byte;
    logic       has_prior_row;
  } item_t;

  // One reconstructed byte as it leaves.
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       error_flag;
    logic       row_end;
  } result_t;

  // Predictor selected by the front part.
  typedef enum logic [2:0] {
    PRED_NONE,
    PRED_SUB,
    PRED_UP,
    PRED_AVG,
    PRED_PAETH
  } pred_t;

  // Classified byte handed from the front part to the back part.
  typedef struct packed {
    pred_t      pred;
    logic       err;
    logic       last;
    logic       has_prior;
    logic       left_ok;
    logic [7:0] data;
  } cmd_t;

endpackage

// ===== rtl/pngu_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module pngu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/pngu_front.sv =====
// Front part: accepts bytes, tracks the column, classifies the filter and reads the prior row.
`timescale 1ns / 1ps
module pngu_front #(
  parameter int COL_W = 13,
  parameter int IDX_W = 3,
  parameter int MAX_ROW_BYTES = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  pngu_pkg::item_t                     item,
  input  logic [pngu_pkg::BPP_W-1:0]          bytes_per_pixel,
  input  logic [pngu_pkg::ROW_BYTES_W-1:0]    row_bytes,
  input  logic [pngu_pkg::QUEUE_LEVEL_W-1:0]  queue_level,
  output logic                                rd_en,
  output logic [COL_W-1:0]                    rd_addr,
  input  logic [7:0]                          rd_data,
  input  logic                                wr_en,
  input  logic [COL_W-1:0]                    wr_addr,
  input  logic [7:0]                          wr_data,
  output logic                                push,
  output pngu_pkg::cmd_t                      push_cmd,
  output logic [COL_W-1:0]                    push_col,
  output logic [IDX_W-1:0]                    push_idx,
  output logic [7:0]                          push_up
);
  import pngu_pkg::*;

  localparam int LW = (COL_W + 1 > ROW_BYTES_W) ? COL_W + 1 : ROW_BYTES_W;

  logic [COL_W-1:0]         col;
  logic                     s1_valid;
  cmd_t                     s1_cmd;
  logic [COL_W-1:0]         s1_col;
  logic [IDX_W-1:0]         s1_idx;
  logic                     s1_fwd_hit;
  logic [7:0]               s1_fwd_data;
  logic                     accept;
  logic [QUEUE_LEVEL_W-1:0] level_sum;
  logic [BPP_W-1:0]         bpp_eff;
  logic [LW-1:0]            len_eff;
  logic [LW-1:0]            col_plus;
  cmd_t                     cmd;

  // Hold off new bytes unless the queue can take this byte and the one in flight.
  assign level_sum  = queue_level + QUEUE_LEVEL_W'(s1_valid);
  assign item_stall = level_sum > QUEUE_LEVEL_W'(QUEUE_DEPTH - 2);
  assign accept     = item_valid && !item_stall;

  // Clamp the registers to their working ranges.
  always_comb begin
    bpp_eff = bytes_per_pixel;
    if (bytes_per_pixel == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bytes_per_pixel > BPP_W'(MAX_PIXEL_BYTES)) begin
      bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
    end
    len_eff = LW'(row_bytes);
    if (row_bytes == '0) begin
      len_eff = LW'(1);
    end else if (LW'(row_bytes) > LW'(MAX_ROW_BYTES)) begin
      len_eff = LW'(MAX_ROW_BYTES);
    end
  end

  assign col_plus = LW'(col) + LW'(1);

  // Decode the filter type and flag the cases that cannot be rebuilt.
  always_comb begin
    cmd.pred      = PRED_NONE;
    cmd.err       = 1'b0;
    cmd.data      = item.data_byte;
    cmd.has_prior = item.has_prior_row;
    cmd.last      = col_plus >= len_eff;
    cmd.left_ok   = LW'(col) >= LW'(bpp_eff);
    unique case (item.filter_type)
      FILTER_NONE:  cmd.pred = PRED_NONE;
      FILTER_SUB:   cmd.pred = PRED_SUB;
      FILTER_UP:    cmd.pred = PRED_UP;
      FILTER_AVG:   cmd.pred = PRED_AVG;
      FILTER_PAETH: cmd.pred = PRED_PAETH;
      default:      cmd.err  = 1'b1;
    endcase
    if (!item.has_prior_row && (item.filter_type == FILTER_UP ||
        item.filter_type == FILTER_AVG || item.filter_type == FILTER_PAETH)) begin
      cmd.err = 1'b1;
    end
  end

  // Read the prior row at the current column as the byte is taken.
  assign rd_en   = accept;
  assign rd_addr = col;

  // Column counter and the stage that waits for the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        col <= cmd.last ? '0 : col_plus[COL_W-1:0];
      end
    end
    if (accept) begin
      s1_cmd      <= cmd;
      s1_col      <= col;
      s1_idx      <= IDX_W'(bpp_eff - BPP_W'(1));
      s1_fwd_hit  <= wr_en && (wr_addr == col);
      s1_fwd_data <= wr_data;
    end
  end

  // The newest write to this column wins over the data read from the store.
  assign push     = s1_valid;
  assign push_cmd = s1_cmd;
  assign push_col = s1_col;
  assign push_idx = s1_idx;
  always_comb begin
    if (wr_en && (wr_addr == s1_col)) begin
      push_up = wr_data;
    end else if (s1_fwd_hit) begin
      push_up = s1_fwd_data;
    end else begin
      push_up = rd_data;
    end
  end

endmodule

// ===== rtl/pngu_queue.sv =====
// Short queue between the front and back parts; queued prior-row bytes follow later writes.
`timescale 1ns / 1ps
module pngu_queue #(
  parameter int COL_W = 13,
  parameter int IDX_W = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  pngu_pkg::cmd_t                      push_cmd,
  input  logic [COL_W-1:0]                    push_col,
  input  logic [IDX_W-1:0]                    push_idx,
  input  logic [7:0]                          push_up,
  input  logic                                pop,
  output logic                                head_valid,
  output pngu_pkg::cmd_t                      head_cmd,
  output logic [COL_W-1:0]                    head_col,
  output logic [IDX_W-1:0]                    head_idx,
  output logic [7:0]                          head_up,
  output logic [pngu_pkg::QUEUE_LEVEL_W-1:0]  level,
  input  logic                                wr_en,
  input  logic [COL_W-1:0]                    wr_addr,
  input  logic [7:0]                          wr_data
);
  import pngu_pkg::*;

  cmd_t             q_cmd [QUEUE_DEPTH];
  logic [COL_W-1:0] q_col [QUEUE_DEPTH];
  logic [IDX_W-1:0] q_idx [QUEUE_DEPTH];
  logic [7:0]       q_up  [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] head;
  logic [QUEUE_PTR_W-1:0] tail;

  assign head_valid = level != '0;
  assign head_cmd   = q_cmd[head];
  assign head_col   = q_col[head];
  assign head_idx   = q_idx[head];
  assign head_up    = q_up[head];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        tail <= tail + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        head <= head + QUEUE_PTR_W'(1);
      end
      level <= level + QUEUE_LEVEL_W'(push) - QUEUE_LEVEL_W'(pop);
    end
  end

  // Entries; every queued byte is younger than the one being written back. A byte
  // pushed in this cycle already carries the newest write to its column.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (push && (tail == QUEUE_PTR_W'(i))) begin
        q_up[i] <= push_up;
      end else if (wr_en && (q_col[i] == wr_addr)) begin
        q_up[i] <= wr_data;
      end
    end
    if (push) begin
      q_cmd[tail] <= push_cmd;
      q_col[tail] <= push_col;
      q_idx[tail] <= push_idx;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> level != QUEUE_LEVEL_W'(QUEUE_DEPTH))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> level != '0)
    else $error("queue read while empty");

endmodule

// ===== rtl/pngu_back.sv =====
// Back part: predictor arithmetic, neighbour histories, line store write-back and result register.
`timescale 1ns / 1ps
module pngu_back #(
  parameter int COL_W = 13,
  parameter int IDX_W = 3,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  pngu_pkg::cmd_t     head_cmd,
  input  logic [COL_W-1:0]   head_col,
  input  logic [IDX_W-1:0]   head_idx,
  input  logic [7:0]         head_up,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output pngu_pkg::result_t  result,
  output logic               wr_en,
  output logic [COL_W-1:0]   wr_addr,
  output logic [7:0]         wr_data
);
  import pngu_pkg::*;

  logic [7:0] left_hist [MAX_PIXEL_BYTES];
  logic [7:0] upl_hist  [MAX_PIXEL_BYTES];
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [8:0] sum_ab;
  logic [7:0] paeth;
  logic [7:0] pred;
  logic [7:0] value;

  // Paeth: distances are |b - c|, |a - c| and |a + b - 2c|.
  function automatic logic [7:0] paeth_pick(input logic [7:0] pa_in, input logic [7:0] pb_in,
                                            input logic [7:0] pc_in);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    da = $signed({3'b000, pb_in}) - $signed({3'b000, pc_in});
    db = $signed({3'b000, pa_in}) - $signed({3'b000, pc_in});
    dc = da + db;
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return pa_in;
    if (db <= dc) return pb_in;
    return pc_in;
  endfunction

  // Take the next byte whenever the result register is free or being emptied.
  assign pop = head_valid && (!result_valid || !result_stall);

  // Neighbours of the current byte.
  assign a      = head_cmd.left_ok ? left_hist[head_idx] : 8'd0;
  assign b      = head_cmd.has_prior ? head_up : 8'd0;
  assign c      = (head_cmd.has_prior && head_cmd.left_ok) ? upl_hist[head_idx] : 8'd0;
  assign sum_ab = {1'b0, a} + {1'b0, b};
  assign paeth  = paeth_pick(a, b, c);

  always_comb begin
    unique case (head_cmd.pred)
      PRED_NONE:  pred = 8'd0;
      PRED_SUB:   pred = a;
      PRED_UP:    pred = b;
      PRED_AVG:   pred = sum_ab[8:1];
      PRED_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase
    value = head_cmd.err ? 8'd0 : head_cmd.data + pred;
  end

  // The rebuilt byte replaces the prior row's byte in the line store.
  assign wr_en   = pop;
  assign wr_addr = head_col;
  assign wr_data = value;

  // Histories and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_hist[k] <= 8'd0;
        upl_hist[k]  <= 8'd0;
      end
    end else begin
      if (pop) begin
        result_valid <= 1'b1;
        for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
          left_hist[k] <= left_hist[k-1];
          upl_hist[k]  <= upl_hist[k-1];
        end
        left_hist[0] <= value;
        upl_hist[0]  <= b;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (pop) begin
      result.pixel_byte <= value;
      result.error_flag <= head_cmd.err;
      result.row_end    <= head_cmd.last;
    end
  end

  a_error_clears_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error_flag |-> result.pixel_byte == 8'd0)
    else $error("flagged byte carries data");

endmodule

// ===== rtl/png_scanline_unfilter.sv =====
// Top level of the PNG scanline unfilter: registers, line store and the three parts.
//
// Usage: filtered scanline bytes enter on the item channel (item_valid, item_stall,
// item) with the row's filter type and the prior-row flag; reconstructed bytes leave
// on the result channel (result_valid, result_stall, result) with an error flag and
// a row-end marker on the last byte of each scanline. A transfer happens on a rising
// edge with valid high and stall low. bytes_per_pixel and row_bytes are written on
// the cfg channel (cfg_ready is always high) while the block is idle. An accepted
// byte passes the front stage register, a queue entry and the result register.
// Unstalled throughput is one byte per cycle, set by the single read and single
// write port of the line store and the one-byte left-neighbour loop in the back
// part. When the receiver stalls, the result register holds, the queue between
// front and back fills and the item channel stalls soon after; nothing is lost.
// Reset clears the column counter, the neighbour histories, the queue and the
// result register and sets both registers to four; the line store is not cleared
// and must be written by a first row before a row that claims a prior row.
`timescale 1ns / 1ps
module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES   = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  pngu_pkg::item_t                      item,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output pngu_pkg::result_t                    result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pngu_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pngu_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pngu_pkg::*;

  localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [BPP_W-1:0]         bytes_per_pixel;
  logic [ROW_BYTES_W-1:0]   row_bytes;
  logic                     rd_en;
  logic [COL_W-1:0]         rd_addr;
  logic [7:0]               rd_data;
  logic                     wr_en;
  logic [COL_W-1:0]         wr_addr;
  logic [7:0]               wr_data;
  logic                     push;
  cmd_t                     push_cmd;
  logic [COL_W-1:0]         push_col;
  logic [IDX_W-1:0]         push_idx;
  logic [7:0]               push_up;
  logic                     pop;
  logic                     head_valid;
  cmd_t                     head_cmd;
  logic [COL_W-1:0]         head_col;
  logic [IDX_W-1:0]         head_idx;
  logic [7:0]               head_up;
  logic [QUEUE_LEVEL_W-1:0] queue_level;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_W'(4);
      row_bytes       <= ROW_BYTES_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[BPP_W-1:0];
        REG_ROW_BYTES:       row_bytes       <= cfg_data[ROW_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Line store holding the prior row.
  pngu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES),
    .AW    (COL_W)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pngu_front #(
    .COL_W           (COL_W),
    .IDX_W           (IDX_W),
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .item            (item),
    .bytes_per_pixel (bytes_per_pixel),
    .row_bytes       (row_bytes),
    .queue_level     (queue_level),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .push            (push),
    .push_cmd        (push_cmd),
    .push_col        (push_col),
    .push_idx        (push_idx),
    .push_up         (push_up)
  );

  pngu_queue #(
    .COL_W (COL_W),
    .IDX_W (IDX_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_col   (push_col),
    .push_idx   (push_idx),
    .push_up    (push_up),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_col   (head_col),
    .head_idx   (head_idx),
    .head_up    (head_up),
    .level      (queue_level),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  pngu_back #(
    .COL_W           (COL_W),
    .IDX_W           (IDX_W),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .head_col     (head_col),
    .head_idx     (head_idx),
    .head_up      (head_up),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

endmodule
